>>> rtl/psgh_pkg.sv
// shared types and constants for the path string guid hash block
// no dependencies; used by every module of the block
`default_nettype none

package psgh_pkg;

	localparam int unsigned NUM_LANES = 4;
	localparam int unsigned BYTE_W    = 8;
	localparam int unsigned WORD_W    = 32;
	localparam int unsigned HASH_W    = 64;
	localparam int unsigned CNT_W     = 32;
	localparam int unsigned MUL_W     = 44;
	localparam int unsigned PROD_W    = MUL_W + BYTE_W;
	localparam int unsigned TERM_SH   = 24;
	localparam int unsigned TERM_W    = HASH_W - TERM_SH;
	localparam int unsigned LEN_W     = 56;
	localparam int unsigned LEN_SPLIT = 28;
	localparam int unsigned LEN_HI_W  = LEN_W - LEN_SPLIT;
	localparam int unsigned PPLO_W    = LEN_SPLIT + CNT_W;
	localparam int unsigned PPHI_W    = HASH_W - LEN_SPLIT;
	localparam int unsigned ACC_W     = 27;
	localparam int unsigned HALF_W    = HASH_W / 2;
	localparam int unsigned ACCLO_W   = ACC_W + HALF_W;
	localparam int unsigned NB_W      = 2;

	localparam logic [WORD_W-1:0] BS_PATTERN  = 32'h5C5C_5C5C;
	localparam logic [WORD_W-1:0] CASE_MASK   = 32'hDFDF_DFDF;
	localparam logic [WORD_W-1:0] LOW_ONES    = 32'h0101_0101;
	localparam logic [WORD_W-1:0] HIGH_BITS   = 32'h8080_8080;
	localparam logic [WORD_W-1:0] SLASH_DELTA = 32'd45;
	localparam logic [MUL_W-1:0]  WORD_MUL    = 44'hFB8_C4D9_6501;
	localparam logic [ACC_W-1:0]  ACC_MUL     = 27'h633_D5F1;
	localparam logic [LEN_W-1:0]  LEN_MUL     = 56'hAE_5028_12AA_7333;
	localparam logic [LEN_SPLIT-1:0] LEN_LO   = LEN_MUL[LEN_SPLIT-1:0];
	localparam logic [LEN_HI_W-1:0]  LEN_HI   = LEN_MUL[LEN_W-1:LEN_SPLIT];

	typedef logic [WORD_W-1:0] word_t;
	typedef logic [HASH_W-1:0] hash_t;
	typedef logic [CNT_W-1:0]  cnt_t;
	typedef logic [TERM_W-1:0] term_t;
	typedef logic [PROD_W-1:0] lane_prod_t;

	// per-word side info: terminating word and bytes kept before the nul
	typedef struct packed {
		logic            last;
		logic [NB_W-1:0] nbytes;
	} tag_t;

	// load enables for the length correction stages
	typedef struct packed {
		logic load_s4;
		logic load_out;
	} fin_ctl_t;

endpackage

`default_nettype wire

>>> rtl/psgh_lane.sv
// one byte lane: partial product of the word multiplier with one name byte
// depends on psgh_pkg
`default_nettype none

module psgh_lane (
	input  wire logic [psgh_pkg::BYTE_W-1:0] byte_in,
	output psgh_pkg::lane_prod_t             prod
);

	assign prod = psgh_pkg::PROD_W'(psgh_pkg::WORD_MUL) * psgh_pkg::PROD_W'(byte_in);

endmodule

`default_nettype wire

>>> rtl/psgh_merge.sv
// merging stage: aligns and sums the lane products into the word term
// depends on psgh_pkg
`default_nettype none

module psgh_merge (
	input  wire logic                 clk,
	input  wire logic                 load,
	input  wire psgh_pkg::lane_prod_t prod [psgh_pkg::NUM_LANES],
	input  wire psgh_pkg::tag_t       tag_in,
	output psgh_pkg::term_t           term_s2,
	output psgh_pkg::tag_t            tag_s2
);

	psgh_pkg::hash_t sum;

	always_comb begin
		sum = '0;
		for (int i = 0; i < psgh_pkg::NUM_LANES; i++) begin
			sum = sum + (psgh_pkg::hash_t'(prod[i]) << (psgh_pkg::BYTE_W * i));
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			term_s2 <= sum[psgh_pkg::HASH_W-1:psgh_pkg::TERM_SH];
			tag_s2  <= tag_in;
		end
	end

endmodule

`default_nettype wire

>>> rtl/psgh_acc.sv
// accumulator: folds each word term into the running hash and byte count
// depends on psgh_pkg; hands the pre-correction sum of an ending word onward
`default_nettype none

module psgh_acc (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            fire,
	input  wire psgh_pkg::term_t term,
	input  wire psgh_pkg::tag_t  tag,
	output psgh_pkg::hash_t      sum_s3,
	output psgh_pkg::cnt_t       cnt_s3
);

	psgh_pkg::hash_t                   hash_q;
	psgh_pkg::cnt_t                    cnt_q;
	logic [psgh_pkg::ACCLO_W-1:0]      mul_lo;
	logic [psgh_pkg::HALF_W-1:0]       mul_hi;
	psgh_pkg::hash_t                   sum;
	psgh_pkg::hash_t                   hash_next;

	// 27x64 multiply split in two 27x32 halves, high half kept mod 2^32
	assign mul_lo = psgh_pkg::ACCLO_W'(psgh_pkg::ACC_MUL)
		* psgh_pkg::ACCLO_W'(hash_q[psgh_pkg::HALF_W-1:0]);
	assign mul_hi = psgh_pkg::HALF_W'(psgh_pkg::ACC_MUL)
		* hash_q[psgh_pkg::HASH_W-1:psgh_pkg::HALF_W];
	assign sum = psgh_pkg::hash_t'(mul_lo) + {mul_hi, psgh_pkg::HALF_W'(0)}
		+ psgh_pkg::hash_t'(term);
	assign hash_next = sum ^ (sum >> 61);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q <= '0;
			cnt_q  <= '0;
		end else if (fire) begin
			if (tag.last) begin
				hash_q <= '0;
				cnt_q  <= '0;
			end else begin
				hash_q <= hash_next;
				cnt_q  <= cnt_q + psgh_pkg::CNT_W'(4);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire && tag.last) begin
			sum_s3 <= sum;
			cnt_s3 <= cnt_q + psgh_pkg::CNT_W'(tag.nbytes);
		end
	end

endmodule

`default_nettype wire

>>> rtl/psgh_fin.sv
// length correction: subtracts the length constant times the byte count
// depends on psgh_pkg; two stages, the product split in 28-bit halves
`default_nettype none

module psgh_fin (
	input  wire logic               clk,
	input  wire psgh_pkg::fin_ctl_t ctl,
	input  wire psgh_pkg::hash_t    sum_s3,
	input  wire psgh_pkg::cnt_t     cnt_s3,
	output psgh_pkg::hash_t         guid_q
);

	logic [psgh_pkg::PPLO_W-1:0] pp_lo;
	logic [psgh_pkg::PPHI_W-1:0] pp_hi;
	logic [psgh_pkg::PPLO_W-1:0] pp_lo_s4;
	logic [psgh_pkg::PPHI_W-1:0] pp_hi_s4;
	psgh_pkg::hash_t             sum_s4;

	assign pp_lo = psgh_pkg::PPLO_W'(psgh_pkg::LEN_LO) * psgh_pkg::PPLO_W'(cnt_s3);
	assign pp_hi = psgh_pkg::PPHI_W'(psgh_pkg::LEN_HI) * psgh_pkg::PPHI_W'(cnt_s3);

	always_ff @(posedge clk) begin
		if (ctl.load_s4) begin
			sum_s4   <= sum_s3;
			pp_lo_s4 <= pp_lo;
			pp_hi_s4 <= pp_hi;
		end
		if (ctl.load_out) begin
			guid_q <= sum_s4 - psgh_pkg::hash_t'(pp_lo_s4)
				- {pp_hi_s4, psgh_pkg::LEN_SPLIT'(0)};
		end
	end

endmodule

`default_nettype wire

>>> rtl/path_string_guid_hash.sv
// path string guid hash top level: normalize, byte lanes, merge, fold, length fix
// depends on psgh_pkg, psgh_lane, psgh_merge, psgh_acc, psgh_fin
// throughput: one name word per cycle when not stalled, limited by hash feedback
// a terminating word passes registers s1, s2, s3 and s4 before out_valid_q
// words without a nul byte give no result; stalls stop the pipe only when full
// reset: arst_n clears the hash, the byte count and every stage valid at once
`default_nettype none

module path_string_guid_hash (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output wire logic                        in_stall,
	input  wire logic [psgh_pkg::WORD_W-1:0] name_word,
	output wire logic                        out_valid,
	input  wire logic                        out_stall,
	output wire logic [psgh_pkg::HASH_W-1:0] guid
);

	// front end: byte normalization and terminator search over the full word
	psgh_pkg::word_t      bs_x;
	psgh_pkg::word_t      bs_hit;
	psgh_pkg::word_t      norm;
	psgh_pkg::word_t      zmask;
	psgh_pkg::word_t      low_bit;
	psgh_pkg::word_t      keep;
	psgh_pkg::word_t      word_in;
	psgh_pkg::tag_t       tag_in;

	// pipeline stage valids and payload
	logic                 vld_s1;
	logic                 vld_s2;
	logic                 vld_s3;
	logic                 vld_s4;
	logic                 out_valid_q;
	psgh_pkg::word_t      word_s1;
	psgh_pkg::tag_t       tag_s1;
	psgh_pkg::term_t      term_s2;
	psgh_pkg::tag_t       tag_s2;
	psgh_pkg::hash_t      sum_s3;
	psgh_pkg::cnt_t       cnt_s3;
	psgh_pkg::hash_t      guid_q;
	psgh_pkg::lane_prod_t prod [psgh_pkg::NUM_LANES];

	// flow control
	logic                 out_free;
	logic                 s4_can;
	logic                 s3_can;
	logic                 fire_s2;
	logic                 s2_can;
	logic                 s1_can;
	logic                 accept;
	psgh_pkg::fin_ctl_t   fin_ctl;

	// backslash test: borrow-based match against the backslash pattern, kept
	// bit exact including its effect on bytes above a match
	assign bs_x   = name_word ^ psgh_pkg::BS_PATTERN;
	assign bs_hit = (~bs_x >> 7) & ((bs_x - psgh_pkg::LOW_ONES) >> 7) & psgh_pkg::LOW_ONES;
	// backslash to slash, then fold to upper case
	assign norm   = (name_word - bs_hit * psgh_pkg::SLASH_DELTA) & psgh_pkg::CASE_MASK;

	// nul detect; lowest flag marks the terminator byte
	assign zmask   = ~name_word & (name_word - psgh_pkg::LOW_ONES) & psgh_pkg::HIGH_BITS;
	assign low_bit = zmask & (psgh_pkg::WORD_W'(0) - zmask);
	// keeps the bytes below the nul plus the low seven bits of the nul byte
	assign keep    = low_bit - psgh_pkg::WORD_W'(1);

	always_comb begin
		tag_in.last   = |zmask;
		tag_in.nbytes = psgh_pkg::NB_W'(3);
		if (zmask[7]) begin
			tag_in.nbytes = psgh_pkg::NB_W'(0);
		end else if (zmask[15]) begin
			tag_in.nbytes = psgh_pkg::NB_W'(1);
		end else if (zmask[23]) begin
			tag_in.nbytes = psgh_pkg::NB_W'(2);
		end
	end

	assign word_in = tag_in.last ? (norm & keep) : norm;

	// backpressure ripples from the output register toward the input; a word
	// without a nul leaves at the accumulator, so only ending words can block
	assign out_free = !out_valid_q || !out_stall;
	assign s4_can   = !vld_s4 || out_free;
	assign s3_can   = !vld_s3 || s4_can;
	assign fire_s2  = vld_s2 && (!tag_s2.last || s3_can);
	assign s2_can   = !vld_s2 || fire_s2;
	assign s1_can   = !vld_s1 || s2_can;
	assign accept   = in_valid && s1_can;
	assign in_stall = !s1_can;

	assign fin_ctl.load_s4  = vld_s3 && s4_can;
	assign fin_ctl.load_out = vld_s4 && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1      <= 1'b0;
			vld_s2      <= 1'b0;
			vld_s3      <= 1'b0;
			vld_s4      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s1_can) begin
				vld_s1 <= in_valid;
			end
			if (s2_can) begin
				vld_s2 <= vld_s1;
			end
			if (s3_can) begin
				vld_s3 <= fire_s2 && tag_s2.last;
			end
			if (s4_can) begin
				vld_s4 <= vld_s3;
			end
			if (out_free) begin
				out_valid_q <= vld_s4;
			end
		end
	end

	// stage 1: normalized word and its tag
	always_ff @(posedge clk) begin
		if (accept) begin
			word_s1 <= word_in;
			tag_s1  <= tag_in;
		end
	end

	// byte lanes: each multiplies its byte by the word constant
	for (genvar i = 0; i < psgh_pkg::NUM_LANES; i++) begin : g_lane
		psgh_lane u_lane (
			.byte_in (word_s1[i*psgh_pkg::BYTE_W +: psgh_pkg::BYTE_W]),
			.prod    (prod[i])
		);
	end

	// stage 2: lane products summed into the shifted word term
	psgh_merge u_merge (
		.clk     (clk),
		.load    (vld_s1 && s2_can),
		.prod    (prod),
		.tag_in  (tag_s1),
		.term_s2 (term_s2),
		.tag_s2  (tag_s2)
	);

	// running hash; an ending word passes its sum and length to stage 3
	psgh_acc u_acc (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire_s2),
		.term   (term_s2),
		.tag    (tag_s2),
		.sum_s3 (sum_s3),
		.cnt_s3 (cnt_s3)
	);

	// stage 4 and output register: length correction
	psgh_fin u_fin (
		.clk    (clk),
		.ctl    (fin_ctl),
		.sum_s3 (sum_s3),
		.cnt_s3 (cnt_s3),
		.guid_q (guid_q)
	);

	assign out_valid = out_valid_q;
	assign guid      = guid_q;

endmodule

`default_nettype wire

>>> rtl/psgh_checker.sv
// port-level checks for the path string guid hash block
// depends on psgh_pkg and the top level's ports; attached with a bind
`default_nettype none

module psgh_checker (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        in_valid,
	input wire logic                        in_stall,
	input wire logic [psgh_pkg::WORD_W-1:0] name_word,
	input wire logic                        out_valid,
	input wire logic                        out_stall,
	input wire logic [psgh_pkg::HASH_W-1:0] guid
);

	logic end_word;

	assign end_word = (name_word[7:0] == 8'd0) || (name_word[15:8] == 8'd0)
		|| (name_word[23:16] == 8'd0) || (name_word[31:24] == 8'd0);

	// a blocked result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(guid))
		else $error("guid changed while stalled");

	// input backpressure only when the output register is full and blocked
	a_stall_cause: assert property (@(posedge clk)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled with the output free");

	// an ending word reaches the output when the output stays free
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$past(in_valid && !in_stall && end_word, 4) && $past(arst_n, 3)
		&& $past(arst_n, 2) && $past(arst_n, 1) && $past(!out_stall, 3)
		&& $past(!out_stall, 2) && $past(!out_stall, 1) && !out_stall
		|=> out_valid)
		else $error("guid missing four cycles after the ending word");

	// nothing leaves in the cycle after reset
	a_reset_clear: assert property (@(posedge clk)
		!$past(arst_n) |-> !out_valid)
		else $error("result present right after reset");

endmodule

bind path_string_guid_hash psgh_checker u_chk (.*);

`default_nettype wire
